>>> hw/rtl/drfsc_pkg.sv
// Shared types and constants for the saturating DSP register file.
// Used by the interfaces, the pipeline modules, the top level and the checker.
package drfsc_pkg;

  // Field widths of one input beat and one result beat.
  localparam int OP_W    = 3;
  localparam int IDX_W   = 4;
  localparam int WV_W    = 64;
  localparam int CODE_W  = 7;
  localparam int FLAG_W  = 7;
  localparam int RV_W    = 41;

  // Register file geometry.
  localparam int ACC_W     = 40;
  localparam int SHORT_W   = 16;
  localparam int NUM_ACC   = 4;
  localparam int NUM_SHORT = 12;
  localparam int NARROW_W  = 32;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_WIDE_MODE = 1'b0;

  // Saturation limits, as stored in the register bits.
  localparam logic [ACC_W-1:0]   ACC_WIDE_MAX   = 40'h7F_FFFF_FFFF;
  localparam logic [ACC_W-1:0]   ACC_WIDE_MIN   = 40'h80_0000_0000;
  localparam logic [ACC_W-1:0]   ACC_NARROW_MAX = 40'h00_7FFF_FFFF;
  localparam logic [ACC_W-1:0]   ACC_NARROW_MIN = 40'hFF_8000_0000;
  localparam logic [SHORT_W-1:0] SHORT_MAX      = 16'h7fff;
  localparam logic [SHORT_W-1:0] SHORT_MIN      = 16'h8000;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_READ       = 3'd0,
    OP_SAT_WRITE  = 3'd1,
    OP_WRITE_LO   = 3'd2,
    OP_WRITE_HI   = 3'd3,
    OP_EVAL_COND  = 3'd4,
    OP_LOAD_FLAGS = 3'd5
  } op_t;

  // Condition test kinds (cond_code bits 6:4).
  localparam logic [2:0] KIND_EQ    = 3'd0;
  localparam logic [2:0] KIND_NE    = 3'd1;
  localparam logic [2:0] KIND_LT    = 3'd2;
  localparam logic [2:0] KIND_LE    = 3'd3;
  localparam logic [2:0] KIND_GT    = 3'd4;
  localparam logic [2:0] KIND_GE    = 3'd5;
  localparam logic [2:0] KIND_FLAG  = 3'd6;
  localparam logic [2:0] KIND_NFLAG = 3'd7;

  // Flag selectors (cond_code bits 3:0) beyond the overflow flags.
  localparam logic [3:0] SEL_TEST1    = 4'd4;
  localparam logic [3:0] SEL_TEST2    = 4'd5;
  localparam logic [3:0] SEL_CARRY    = 4'd6;
  localparam logic [3:0] SEL_RESERVED = 4'd7;

  // Bit positions in flag_bits.
  localparam int FB_TEST1 = 4;
  localparam int FB_TEST2 = 5;
  localparam int FB_CARRY = 6;

  // One input beat.
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         reg_index;
    logic                     signed_read;
    logic signed [WV_W-1:0]   write_value;
    logic                     saturate_enable;
    logic [CODE_W-1:0]        cond_code;
    logic [FLAG_W-1:0]        flag_bits;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic signed [RV_W-1:0]   read_value;
    logic                     condition_true;
    logic                     overflowed;
  } result_t;

endpackage

>>> hw/rtl/drfsc_in_if.sv
// Input channel of the register file: valid/ready plus one operation beat.
// Depends on drfsc_pkg for field widths.
interface drfsc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [drfsc_pkg::OP_W-1:0]             operation;
  logic [drfsc_pkg::IDX_W-1:0]            reg_index;
  logic                                   signed_read;
  logic signed [drfsc_pkg::WV_W-1:0]      write_value;
  logic                                   saturate_enable;
  logic [drfsc_pkg::CODE_W-1:0]           cond_code;
  logic [drfsc_pkg::FLAG_W-1:0]           flag_bits;

  modport source (
    output valid, operation, reg_index, signed_read, write_value,
           saturate_enable, cond_code, flag_bits,
    input  ready
  );
  modport sink (
    input  valid, operation, reg_index, signed_read, write_value,
           saturate_enable, cond_code, flag_bits,
    output ready
  );
endinterface

>>> hw/rtl/drfsc_out_if.sv
// Result channel of the register file: valid/ready plus one result beat.
// Depends on drfsc_pkg for field widths.
interface drfsc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [drfsc_pkg::RV_W-1:0]      read_value;
  logic                                   condition_true;
  logic                                   overflowed;

  modport source (
    output valid, read_value, condition_true, overflowed,
    input  ready
  );
  modport sink (
    input  valid, read_value, condition_true, overflowed,
    output ready
  );
endinterface

>>> hw/rtl/drfsc_in_stage.sv
// Input register of the register file pipeline: captures one beat.
// Depends on drfsc_pkg and drfsc_in_if.
module drfsc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  drfsc_in_if.sink            in_beat,
  input  logic                advance,
  output logic                item_valid,
  output drfsc_pkg::item_t    item
);

  logic             valid_r;
  logic             valid_nxt;
  drfsc_pkg::item_t item_r;
  logic             take;

  // A new beat is taken when the register is empty or moves on this cycle.
  assign in_beat.ready = rst_n & (~valid_r | advance);
  assign take          = in_beat.valid & in_beat.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.operation       <= in_beat.operation;
      item_r.reg_index       <= in_beat.reg_index;
      item_r.signed_read     <= in_beat.signed_read;
      item_r.write_value     <= in_beat.write_value;
      item_r.saturate_enable <= in_beat.saturate_enable;
      item_r.cond_code       <= in_beat.cond_code;
      item_r.flag_bits       <= in_beat.flag_bits;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> hw/rtl/drfsc_core.sv
// Register file state and the single-pass datapath: read views, saturating
// writes, word writes, condition tests and flag loads. Depends on drfsc_pkg.
module drfsc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wide_mode,
  input  logic                fire,
  input  drfsc_pkg::item_t    item,
  output drfsc_pkg::result_t  result
);

  localparam int AW = drfsc_pkg::ACC_W;
  localparam int SW = drfsc_pkg::SHORT_W;
  localparam int RW = drfsc_pkg::RV_W;
  localparam int WW = drfsc_pkg::WV_W;
  localparam int NW = drfsc_pkg::NARROW_W;

  // Architectural state.
  logic [AW-1:0] acc_r   [drfsc_pkg::NUM_ACC];
  logic [SW-1:0] short_r [drfsc_pkg::NUM_SHORT];
  logic [drfsc_pkg::NUM_ACC-1:0] ovf_r;
  logic          test1_r;
  logic          test2_r;
  logic          carry_r;

  drfsc_pkg::op_t  op;
  logic            is_eval;
  logic [3:0]      sel;
  logic            sel_is_acc;
  logic [AW-1:0]   acc_rd;
  logic [3:0]      sh_idx;
  logic [SW-1:0]   sh_rd;
  logic            ext;
  logic [RW-1:0]   view;
  logic            v_neg;
  logic            v_zero;
  logic [2:0]      kind;
  logic [3:0]      fsel;
  logic            fa;
  logic            fb;
  logic            flag_val;
  logic            cond;
  logic            acc_fit;
  logic            sh_fit;
  logic            ovf;
  logic            wneg;
  logic [AW-1:0]   acc_wr;
  logic [SW-1:0]   sh_wr;
  logic [WW-1:0]   wv;

  // Select the one register this beat touches and form its extended view.
  always_comb begin
    op         = drfsc_pkg::op_t'(item.operation);
    is_eval    = (op == drfsc_pkg::OP_EVAL_COND);
    sel        = is_eval ? item.cond_code[3:0] : item.reg_index;
    sel_is_acc = (sel[3:2] == 2'b00);
    acc_rd     = acc_r[sel[1:0]];
    sh_idx     = sel_is_acc ? 4'd0 : (sel - 4'(drfsc_pkg::NUM_ACC));
    sh_rd      = short_r[sh_idx];
    ext        = is_eval | item.signed_read;
    if (sel_is_acc) begin
      if (wide_mode) begin
        view = {ext & acc_rd[AW-1], acc_rd};
      end else begin
        view = {{(RW-NW){ext & acc_rd[NW-1]}}, acc_rd[NW-1:0]};
      end
    end else begin
      view = {{(RW-SW){ext & sh_rd[SW-1]}}, sh_rd};
    end
    v_neg  = view[RW-1];
    v_zero = (view == '0);
  end

  // Condition evaluation over the register view or the flags.
  always_comb begin
    kind = item.cond_code[6:4];
    fsel = item.cond_code[3:0];
    fa   = fsel[1] ? ~test1_r : test1_r;
    fb   = fsel[0] ? ~test2_r : test2_r;
    case (fsel)
      4'd0, 4'd1, 4'd2, 4'd3: flag_val = ovf_r[fsel[1:0]];
      drfsc_pkg::SEL_TEST1:   flag_val = test1_r;
      drfsc_pkg::SEL_TEST2:   flag_val = test2_r;
      drfsc_pkg::SEL_CARRY:   flag_val = carry_r;
      default:                flag_val = 1'b0;
    endcase
    case (kind)
      drfsc_pkg::KIND_EQ: cond = v_zero;
      drfsc_pkg::KIND_NE: cond = ~v_zero;
      drfsc_pkg::KIND_LT: cond = v_neg;
      drfsc_pkg::KIND_LE: cond = v_neg | v_zero;
      drfsc_pkg::KIND_GT: cond = ~v_neg & ~v_zero;
      drfsc_pkg::KIND_GE: cond = ~v_neg;
      drfsc_pkg::KIND_FLAG: begin
        if (fsel == drfsc_pkg::SEL_RESERVED) begin
          cond = 1'b0;
        end else if (fsel[3] == 1'b0) begin
          cond = flag_val;
        end else if (fsel[2] == 1'b0) begin
          cond = fa & fb;
        end else begin
          cond = 1'b0;
        end
      end
      default: begin
        if (fsel == drfsc_pkg::SEL_RESERVED) begin
          cond = 1'b0;
        end else if (fsel[3] == 1'b0) begin
          cond = ~flag_val;
        end else if (fsel[2] == 1'b0) begin
          cond = fa | fb;
        end else begin
          cond = fa ^ fb;
        end
      end
    endcase
  end

  // Range check and clamp: the value fits when all bits above the limit's
  // sign bit agree with it.
  always_comb begin
    wv      = item.write_value;
    wneg    = wv[WW-1];
    acc_fit = wide_mode ? ((&wv[WW-1:AW-1]) | ~(|wv[WW-1:AW-1]))
                        : ((&wv[WW-1:NW-1]) | ~(|wv[WW-1:NW-1]));
    sh_fit  = (&wv[WW-1:SW-1]) | ~(|wv[WW-1:SW-1]);
    ovf     = ~(sel_is_acc ? acc_fit : sh_fit);
    acc_wr  = wv[AW-1:0];
    sh_wr   = wv[SW-1:0];
    if (ovf && item.saturate_enable) begin
      if (wide_mode) begin
        acc_wr = wneg ? drfsc_pkg::ACC_WIDE_MIN : drfsc_pkg::ACC_WIDE_MAX;
      end else begin
        acc_wr = wneg ? drfsc_pkg::ACC_NARROW_MIN : drfsc_pkg::ACC_NARROW_MAX;
      end
      sh_wr = wneg ? drfsc_pkg::SHORT_MIN : drfsc_pkg::SHORT_MAX;
    end
  end

  // Result fields for this beat.
  always_comb begin
    result.read_value     = (op == drfsc_pkg::OP_READ) ? view : '0;
    result.condition_true = is_eval & cond;
    result.overflowed     = (op == drfsc_pkg::OP_SAT_WRITE) & ovf;
  end

  // State update when the beat moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < drfsc_pkg::NUM_ACC; i++) begin
        acc_r[i] <= '0;
      end
      for (int i = 0; i < drfsc_pkg::NUM_SHORT; i++) begin
        short_r[i] <= '0;
      end
      ovf_r   <= '0;
      test1_r <= 1'b0;
      test2_r <= 1'b0;
      carry_r <= 1'b0;
    end else if (fire) begin
      case (op)
        drfsc_pkg::OP_SAT_WRITE: begin
          if (sel_is_acc) begin
            acc_r[sel[1:0]] <= acc_wr;
            if (ovf) begin
              ovf_r[sel[1:0]] <= 1'b1;
            end
          end else begin
            short_r[sh_idx] <= sh_wr;
          end
        end
        drfsc_pkg::OP_WRITE_LO: begin
          if (sel_is_acc) begin
            acc_r[sel[1:0]] <= {acc_rd[AW-1:SW], wv[SW-1:0]};
          end else begin
            short_r[sh_idx] <= wv[SW-1:0];
          end
        end
        drfsc_pkg::OP_WRITE_HI: begin
          if (sel_is_acc) begin
            acc_r[sel[1:0]] <= {acc_rd[AW-1:NW], wv[SW-1:0], acc_rd[SW-1:0]};
          end else begin
            short_r[sh_idx] <= wv[SW-1:0];
          end
        end
        drfsc_pkg::OP_LOAD_FLAGS: begin
          ovf_r   <= item.flag_bits[drfsc_pkg::NUM_ACC-1:0];
          test1_r <= item.flag_bits[drfsc_pkg::FB_TEST1];
          test2_r <= item.flag_bits[drfsc_pkg::FB_TEST2];
          carry_r <= item.flag_bits[drfsc_pkg::FB_CARRY];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/drfsc_out_stage.sv
// Result register of the register file pipeline; drives the result channel.
// Depends on drfsc_pkg and drfsc_out_if.
module drfsc_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  drfsc_pkg::result_t   result,
  output logic                 advance,
  drfsc_out_if.source          out_beat
);

  logic               valid_r;
  logic               valid_nxt;
  drfsc_pkg::result_t result_r;

  // The register can take a new result when empty or being drained.
  assign advance = ~valid_r | out_beat.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_beat.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_beat.valid          = valid_r;
  assign out_beat.read_value     = result_r.read_value;
  assign out_beat.condition_true = result_r.condition_true;
  assign out_beat.overflowed     = result_r.overflowed;

endmodule

>>> hw/rtl/dsp_register_file_saturate_condition.sv
// DSP register file with four 40-bit accumulators (index 0-3), T0-T3 (4-7)
// and AR0-AR7 (8-15), sticky overflow flags, two test flags and a carry.
// Each input beat is one operation and yields exactly one result beat.
// Throughput is one beat per clock while results drain; an accepted beat
// goes from the input register into the result register, which offers
// its result, with all work done in the logic between the input register and
// the result register. While a result beat is stalled, the next beat waits in
// the input register and the input stops accepting. The next beat sees
// every state change made by the one before it. The wide_mode register at
// byte address 0 selects the 40-bit (1) or 32-bit (0) accumulator view and
// saturation; write it only while no beat is in flight.
// Depends on drfsc_pkg, drfsc_in_if, drfsc_out_if and the drfsc_ stages.
module dsp_register_file_saturate_condition (
  input  logic                                 clk,
  input  logic                                 rst_n,
  drfsc_in_if.sink                             in_beat,
  drfsc_out_if.source                          out_beat,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [drfsc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [drfsc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [drfsc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  logic                  wide_mode_r;
  logic                  wide_mode_nxt;
  logic                  cfg_wr;
  logic                  fire;
  logic                  item_valid;
  logic                  advance;
  drfsc_pkg::item_t      item;
  drfsc_pkg::result_t    result;

  // Configuration register write and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready &
                  (paddr[2] == drfsc_pkg::CFG_IDX_WIDE_MODE);

  always_comb begin
    wide_mode_nxt = cfg_wr ? pwdata[0] : wide_mode_r;
    prdata        = '0;
    if (paddr[2] == drfsc_pkg::CFG_IDX_WIDE_MODE) begin
      prdata[0] = wide_mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_mode_r <= 1'b0;
    end else begin
      wide_mode_r <= wide_mode_nxt;
    end
  end

  // Input register.
  drfsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_beat    (in_beat),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // A beat executes when it moves into the result register.
  assign fire = item_valid & advance;

  drfsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .wide_mode (wide_mode_r),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  // Result register.
  drfsc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .result   (result),
    .advance  (advance),
    .out_beat (out_beat)
  );

endmodule

>>> hw/rtl/drfsc_checker.sv
// Port-level checks for the register file, bound to the top level.
// Depends on drfsc_pkg for field widths.
module drfsc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [drfsc_pkg::RV_W-1:0] read_value,
  input logic                              condition_true,
  input logic                              overflowed
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(read_value) && $stable(condition_true)
                                && $stable(overflowed))
    else $error("result payload changed while stalled");

  // Every accepted beat has a result on offer once it has passed the input register and the result register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing two clocks after an accepted beat");

  // A result comes from one operation only: a true condition and an
  // overflow never share a beat, and neither goes with a read value.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(condition_true && overflowed) &&
                  (read_value == '0 || (!condition_true && !overflowed)))
    else $error("result mixes fields of different operations");

endmodule

bind dsp_register_file_saturate_condition drfsc_checker u_drfsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_beat.valid),
  .in_ready       (in_beat.ready),
  .out_valid      (out_beat.valid),
  .out_ready      (out_beat.ready),
  .read_value     (out_beat.read_value),
  .condition_true (out_beat.condition_true),
  .overflowed     (out_beat.overflowed)
);
